// File: hw/rtl/cdiv_pkg.sv
// shared constants, register codes and helpers for the clock synthesizer divider calculator
`default_nettype none

package cdiv_pkg;

   // field widths
   localparam int IN_CH_W   = 8;
   localparam int IN_FREQ_W = 32;
   localparam int OUT_CH_W  = 2;
   localparam int REXP_W    = 3;
   localparam int XTAL_W    = 26;
   localparam int HZ_W      = 29;
   localparam int MSDIV_W   = 12;
   localparam int MULT_W    = 8;
   localparam int P1_W      = 18;
   localparam int FRAC_W    = 20;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 29;
   localparam int VCO_W     = MSDIV_W + HZ_W;
   localparam int NUM_W     = XTAL_W + FRAC_W;
   localparam int TGT_W     = 30;

   localparam int DEF_NUM_CHANNELS = 3;

   // arithmetic constants
   localparam logic [TGT_W-1:0]  VCO_TARGET_HZ = 30'd900000000;
   localparam logic [FRAC_W-1:0] FRAC_DEN      = 20'd1048575;
   // largest frequency whose quotient 900 MHz / f still reaches 4096
   localparam logic [HZ_W-1:0]   DIV_SAT_HZ    = 29'd219726;
   localparam logic [P1_W-1:0]   P1_OFFSET     = 18'd512;

   // register reset values
   localparam logic [XTAL_W-1:0]  XTAL_RST      = 26'd25000000;
   localparam logic [HZ_W-1:0]    OUT_MIN_RST   = 29'd500000;
   localparam logic [HZ_W-1:0]    OUT_MAX_RST   = 29'd200000000;
   localparam logic [MSDIV_W-1:0] MS_MIN_RST    = 12'd4;
   localparam logic [MSDIV_W-1:0] MS_MAX_RST    = 12'd900;
   localparam logic [MULT_W-1:0]  MULT_MIN_RST  = 8'd15;
   localparam logic [MULT_W-1:0]  MULT_MAX_RST  = 8'd90;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_XTAL_HZ       = 3'd0,
      CSR_OUT_MIN_HZ    = 3'd1,
      CSR_OUT_MAX_HZ    = 3'd2,
      CSR_MS_DIV_MIN    = 3'd3,
      CSR_MS_DIV_MAX    = 3'd4,
      CSR_PLL_MULT_MIN  = 3'd5,
      CSR_PLL_MULT_MAX  = 3'd6,
      CSR_RESET_PLL_EN  = 3'd7
   } csr_idx_type;

   // power-of-two output divider exponent, eight bands, seven of them below 512 kHz
   function automatic logic [REXP_W-1:0] band_exponent(input logic [IN_FREQ_W-1:0] f);
      logic [REXP_W-1:0] e;
      begin
         if (f < 32'd8000)        e = 3'd7;
         else if (f < 32'd16000)  e = 3'd6;
         else if (f < 32'd32000)  e = 3'd5;
         else if (f < 32'd64000)  e = 3'd4;
         else if (f < 32'd128000) e = 3'd3;
         else if (f < 32'd256000) e = 3'd2;
         else if (f < 32'd512000) e = 3'd1;
         else                     e = 3'd0;
         return e;
      end
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/clock_synth_divider_calc_unit.sv
// top level: pipelined clock synthesizer divider calculator
//
// A request carries a channel and a wanted output frequency; each request
// produces exactly one response with the output divider exponent, the even
// output divider and its P1 code, and the PLL multiplier split into integer
// part, fraction numerator and P1/P2 codes.
// Both channels are valid/ready. A new request is taken every cycle while
// no response is held. The three restoring dividers produce one quotient
// bit per stage (12 bits for the output divider, 41 bits for the multiplier,
// 20 bits for the fraction).
// When the receiver holds rsp_ready low with a response waiting, the whole
// pipeline freezes and req_ready drops; nothing is lost or repeated.
// The csr_ port writes one setting register per cycle with csr_write_enable;
// settings are read live, so write them only while the pipeline is empty.
// Reset (synchronous, active high) empties the pipeline and loads the
// default settings: 25 MHz crystal, 500 kHz .. 200 MHz window, divider
// limits 4 .. 900, multiplier limits 15 .. 90, PLL reset request off.
`default_nettype none

module clock_synth_divider_calc_unit #(
   parameter int NUM_CHANNELS = cdiv_pkg::DEF_NUM_CHANNELS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire logic [cdiv_pkg::IN_CH_W-1:0]     req_channel,
   input  wire logic [cdiv_pkg::IN_FREQ_W-1:0]   req_freq_hz,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      logic [cdiv_pkg::OUT_CH_W-1:0]    rsp_out_channel,
   output      logic [cdiv_pkg::REXP_W-1:0]      rsp_r_div_log2,
   output      logic [cdiv_pkg::MSDIV_W-1:0]     rsp_ms_div,
   output      logic [cdiv_pkg::P1_W-1:0]        rsp_ms_p1,
   output      logic [cdiv_pkg::MULT_W-1:0]      rsp_pll_mult_int,
   output      logic [cdiv_pkg::FRAC_W-1:0]      rsp_pll_frac_num,
   output      logic [cdiv_pkg::P1_W-1:0]        rsp_pll_p1,
   output      logic [cdiv_pkg::FRAC_W-1:0]      rsp_pll_p2,
   output      logic                             rsp_pll_reset_request,
   input  wire logic                             csr_write_enable,
   input  wire logic [cdiv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [cdiv_pkg::CSR_W-1:0]       csr_write_data
);
   import cdiv_pkg::*;

   localparam int B_ST = MSDIV_W;
   localparam int E_ST = VCO_W;
   localparam int G_ST = FRAC_W;
   localparam logic [IN_CH_W-1:0] LAST_CH = IN_CH_W'(NUM_CHANNELS - 1);

   // setting registers
   logic [XTAL_W-1:0]  xtal_hz_ff;
   logic [HZ_W-1:0]    out_min_hz_ff;
   logic [HZ_W-1:0]    out_max_hz_ff;
   logic [MSDIV_W-1:0] ms_div_min_ff;
   logic [MSDIV_W-1:0] ms_div_max_ff;
   logic [MULT_W-1:0]  pll_mult_min_ff;
   logic [MULT_W-1:0]  pll_mult_max_ff;
   logic               reset_pll_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         xtal_hz_ff          <= XTAL_RST;
         out_min_hz_ff       <= OUT_MIN_RST;
         out_max_hz_ff       <= OUT_MAX_RST;
         ms_div_min_ff       <= MS_MIN_RST;
         ms_div_max_ff       <= MS_MAX_RST;
         pll_mult_min_ff     <= MULT_MIN_RST;
         pll_mult_max_ff     <= MULT_MAX_RST;
         reset_pll_enable_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_idx_type'(csr_index))
            CSR_XTAL_HZ:      xtal_hz_ff          <= csr_write_data[XTAL_W-1:0];
            CSR_OUT_MIN_HZ:   out_min_hz_ff       <= csr_write_data[HZ_W-1:0];
            CSR_OUT_MAX_HZ:   out_max_hz_ff       <= csr_write_data[HZ_W-1:0];
            CSR_MS_DIV_MIN:   ms_div_min_ff       <= csr_write_data[MSDIV_W-1:0];
            CSR_MS_DIV_MAX:   ms_div_max_ff       <= csr_write_data[MSDIV_W-1:0];
            CSR_PLL_MULT_MIN: pll_mult_min_ff     <= csr_write_data[MULT_W-1:0];
            CSR_PLL_MULT_MAX: pll_mult_max_ff     <= csr_write_data[MULT_W-1:0];
            CSR_RESET_PLL_EN: reset_pll_enable_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves unless a response is held
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // ---------------------------------------------------------------
   // band select, scale, window clamp, channel clamp
   logic [REXP_W-1:0]       a_rexp_in;
   logic [HZ_W+10-1:0]      a_scaled;
   logic [HZ_W+10-1:0]      a_floor;
   logic [HZ_W-1:0]         a_f_in;
   logic [IN_CH_W-1:0]      a_ch_in;

   always_comb begin
      a_rexp_in = band_exponent(req_freq_hz);
      a_scaled  = {7'b0, req_freq_hz} << a_rexp_in;
      a_floor   = (a_scaled < {10'b0, out_min_hz_ff}) ? {10'b0, out_min_hz_ff} : a_scaled;
      a_f_in    = (a_floor > {10'b0, out_max_hz_ff}) ? out_max_hz_ff : a_floor[HZ_W-1:0];
      a_ch_in   = (req_channel > LAST_CH) ? LAST_CH : req_channel;
   end

   // output divider quotient 900 MHz / f, one bit per stage
   logic                b_valid_ff [0:B_ST];
   logic [OUT_CH_W-1:0] b_ch_ff    [0:B_ST];
   logic [REXP_W-1:0]   b_rexp_ff  [0:B_ST];
   logic [HZ_W-1:0]     b_f_ff     [0:B_ST];
   logic                b_sat_ff   [0:B_ST];
   logic [TGT_W-1:0]    b_rem_ff   [0:B_ST];
   logic [MSDIV_W-1:0]  b_quo_ff   [0:B_ST];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         b_valid_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_ch_ff[0]   <= a_ch_in[OUT_CH_W-1:0];
         b_rexp_ff[0] <= a_rexp_in;
         b_f_ff[0]    <= a_f_in;
         b_sat_ff[0]  <= (a_f_in <= DIV_SAT_HZ);
         b_rem_ff[0]  <= VCO_TARGET_HZ;
         b_quo_ff[0]  <= '0;
      end
   end

   for (genvar j = 1; j <= B_ST; j++) begin : g_bdiv
      localparam int SH = B_ST - j;
      logic [TGT_W+MSDIV_W-1:0] trial;
      logic                     ge;
      logic [TGT_W-1:0]         rem_in;
      logic [MSDIV_W-1:0]       quo_in;

      // restoring step for quotient bit SH
      always_comb begin
         trial  = {{(TGT_W+MSDIV_W-HZ_W){1'b0}}, b_f_ff[j-1]} << SH;
         ge     = {{MSDIV_W{1'b0}}, b_rem_ff[j-1]} >= trial;
         rem_in = ge ? (b_rem_ff[j-1] - trial[TGT_W-1:0]) : b_rem_ff[j-1];
         quo_in = b_quo_ff[j-1] | (MSDIV_W'(ge) << SH);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            b_valid_ff[j] <= 1'b0;
         end else if (adv) begin
            b_valid_ff[j] <= b_valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            b_ch_ff[j]   <= b_ch_ff[j-1];
            b_rexp_ff[j] <= b_rexp_ff[j-1];
            b_f_ff[j]    <= b_f_ff[j-1];
            b_sat_ff[j]  <= b_sat_ff[j-1];
            b_rem_ff[j]  <= rem_in;
            b_quo_ff[j]  <= quo_in;
         end
      end
   end

   // divider clamp and even rounding
   logic                c_valid_ff;
   logic [OUT_CH_W-1:0] c_ch_ff;
   logic [REXP_W-1:0]   c_rexp_ff;
   logic [HZ_W-1:0]     c_f_ff;
   logic [MSDIV_W-1:0]  c_div_ff;
   logic [MSDIV_W-1:0]  c_hi;
   logic [MSDIV_W-1:0]  c_lo;
   logic [MSDIV_W-1:0]  c_div_in;

   always_comb begin
      c_hi     = (b_sat_ff[B_ST] || (b_quo_ff[B_ST] > ms_div_max_ff)) ?
                 ms_div_max_ff : b_quo_ff[B_ST];
      c_lo     = (c_hi < ms_div_min_ff) ? ms_div_min_ff : c_hi;
      c_div_in = {c_lo[MSDIV_W-1:1], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= b_valid_ff[B_ST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ch_ff   <= b_ch_ff[B_ST];
         c_rexp_ff <= b_rexp_ff[B_ST];
         c_f_ff    <= b_f_ff[B_ST];
         c_div_ff  <= c_div_in;
      end
   end

   // vco = divider * f, loaded into the multiplier divider
   logic                e_valid_ff [0:E_ST];
   logic [OUT_CH_W-1:0] e_ch_ff    [0:E_ST];
   logic [REXP_W-1:0]   e_rexp_ff  [0:E_ST];
   logic [MSDIV_W-1:0]  e_div_ff   [0:E_ST];
   logic [VCO_W-1:0]    e_rem_ff   [0:E_ST];
   logic [MULT_W-1:0]   e_quo_ff   [0:E_ST];
   logic                e_sat_ff   [0:E_ST];

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         e_valid_ff[0] <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_ch_ff[0]   <= c_ch_ff;
         e_rexp_ff[0] <= c_rexp_ff;
         e_div_ff[0]  <= c_div_ff;
         e_rem_ff[0]  <= {{HZ_W{1'b0}}, c_div_ff} * {{MSDIV_W{1'b0}}, c_f_ff};
         e_quo_ff[0]  <= '0;
         e_sat_ff[0]  <= 1'b0;
      end
   end

   for (genvar j = 1; j <= E_ST; j++) begin : g_ediv
      localparam int SH = E_ST - j;
      logic [VCO_W+XTAL_W-1:0] trial;
      logic                    ge;
      logic [VCO_W-1:0]        rem_in;
      logic [MULT_W-1:0]       quo_in;
      logic                    sat_in;

      // restoring step; quotient bits above the multiplier width only saturate
      always_comb begin
         trial  = {{VCO_W{1'b0}}, xtal_hz_ff} << SH;
         ge     = {{XTAL_W{1'b0}}, e_rem_ff[j-1]} >= trial;
         rem_in = ge ? (e_rem_ff[j-1] - trial[VCO_W-1:0]) : e_rem_ff[j-1];
         if (SH >= MULT_W) begin
            quo_in = e_quo_ff[j-1];
            sat_in = e_sat_ff[j-1] | ge;
         end else begin
            quo_in = e_quo_ff[j-1] | (MULT_W'(ge) << (SH % MULT_W));
            sat_in = e_sat_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            e_valid_ff[j] <= 1'b0;
         end else if (adv) begin
            e_valid_ff[j] <= e_valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            e_ch_ff[j]   <= e_ch_ff[j-1];
            e_rexp_ff[j] <= e_rexp_ff[j-1];
            e_div_ff[j]  <= e_div_ff[j-1];
            e_rem_ff[j]  <= rem_in;
            e_quo_ff[j]  <= quo_in;
            e_sat_ff[j]  <= sat_in;
         end
      end
   end

   // multiplier clamp and fraction dividend remainder * 1048575
   logic [MULT_W-1:0] f_hi;
   logic [MULT_W-1:0] f_a_in;
   logic [XTAL_W-1:0] f_r;
   logic [NUM_W-1:0]  f_num_in;

   always_comb begin
      f_hi     = (e_sat_ff[E_ST] || (e_quo_ff[E_ST] > pll_mult_max_ff)) ?
                 pll_mult_max_ff : e_quo_ff[E_ST];
      f_a_in   = (f_hi < pll_mult_min_ff) ? pll_mult_min_ff : f_hi;
      f_r      = e_rem_ff[E_ST][XTAL_W-1:0];
      f_num_in = {f_r, {FRAC_W{1'b0}}} - {{FRAC_W{1'b0}}, f_r};
   end

   // fraction quotient, one bit per stage
   logic                g_valid_ff [0:G_ST];
   logic [OUT_CH_W-1:0] g_ch_ff    [0:G_ST];
   logic [REXP_W-1:0]   g_rexp_ff  [0:G_ST];
   logic [MSDIV_W-1:0]  g_div_ff   [0:G_ST];
   logic [MULT_W-1:0]   g_a_ff     [0:G_ST];
   logic                g_xz_ff    [0:G_ST];
   logic [NUM_W-1:0]    g_rem_ff   [0:G_ST];
   logic [FRAC_W-1:0]   g_quo_ff   [0:G_ST];

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         g_valid_ff[0] <= e_valid_ff[E_ST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_ch_ff[0]   <= e_ch_ff[E_ST];
         g_rexp_ff[0] <= e_rexp_ff[E_ST];
         g_div_ff[0]  <= e_div_ff[E_ST];
         g_a_ff[0]    <= f_a_in;
         g_xz_ff[0]   <= (xtal_hz_ff == '0);
         g_rem_ff[0]  <= f_num_in;
         g_quo_ff[0]  <= '0;
      end
   end

   for (genvar j = 1; j <= G_ST; j++) begin : g_gdiv
      localparam int SH = G_ST - j;
      logic [NUM_W-1:0]  trial;
      logic              ge;
      logic [NUM_W-1:0]  rem_in;
      logic [FRAC_W-1:0] quo_in;

      // restoring step for fraction bit SH
      always_comb begin
         trial  = {{FRAC_W{1'b0}}, xtal_hz_ff} << SH;
         ge     = g_rem_ff[j-1] >= trial;
         rem_in = ge ? (g_rem_ff[j-1] - trial) : g_rem_ff[j-1];
         quo_in = g_quo_ff[j-1] | (FRAC_W'(ge) << SH);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            g_valid_ff[j] <= 1'b0;
         end else if (adv) begin
            g_valid_ff[j] <= g_valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            g_ch_ff[j]   <= g_ch_ff[j-1];
            g_rexp_ff[j] <= g_rexp_ff[j-1];
            g_div_ff[j]  <= g_div_ff[j-1];
            g_a_ff[j]    <= g_a_ff[j-1];
            g_xz_ff[j]   <= g_xz_ff[j-1];
            g_rem_ff[j]  <= rem_in;
            g_quo_ff[j]  <= quo_in;
         end
      end
   end

   // P1/P2 encoding; 128b / 1048575 by one fold and one correction
   logic [FRAC_W-1:0]   h_b;
   logic [FRAC_W+6:0]   h_x;
   logic [6:0]          h_q0;
   logic [FRAC_W:0]     h_r;
   logic                h_ge;
   logic [6:0]          h_fq;
   logic [FRAC_W-1:0]   h_p2_in;
   logic [P1_W-1:0]     h_p1_in;
   logic [P1_W-1:0]     h_ms_p1_in;

   always_comb begin
      h_b        = g_xz_ff[G_ST] ? '0 : g_quo_ff[G_ST];
      h_x        = {h_b, 7'b0};
      h_q0       = h_x[FRAC_W+6:FRAC_W];
      h_r        = {1'b0, h_x[FRAC_W-1:0]} + (FRAC_W+1)'(h_q0);
      h_ge       = h_r >= {1'b0, FRAC_DEN};
      h_fq       = h_ge ? (h_q0 + 7'd1) : h_q0;
      h_p2_in    = h_ge ? (h_r[FRAC_W-1:0] - FRAC_DEN) : h_r[FRAC_W-1:0];
      h_p1_in    = P1_W'({g_a_ff[G_ST], 7'b0}) + P1_W'(h_fq) - P1_OFFSET;
      h_ms_p1_in = P1_W'({g_div_ff[G_ST], 7'b0}) - P1_OFFSET;
   end

   // response register
   logic [OUT_CH_W-1:0] rsp_ch_ff;
   logic [REXP_W-1:0]   rsp_rexp_ff;
   logic [MSDIV_W-1:0]  rsp_div_ff;
   logic [P1_W-1:0]     rsp_ms_p1_ff;
   logic [MULT_W-1:0]   rsp_a_ff;
   logic [FRAC_W-1:0]   rsp_b_ff;
   logic [P1_W-1:0]     rsp_p1_ff;
   logic [FRAC_W-1:0]   rsp_p2_ff;
   logic                rsp_rst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= g_valid_ff[G_ST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ch_ff    <= g_ch_ff[G_ST];
         rsp_rexp_ff  <= g_rexp_ff[G_ST];
         rsp_div_ff   <= g_div_ff[G_ST];
         rsp_ms_p1_ff <= h_ms_p1_in;
         rsp_a_ff     <= g_a_ff[G_ST];
         rsp_b_ff     <= h_b;
         rsp_p1_ff    <= h_p1_in;
         rsp_p2_ff    <= h_p2_in;
         rsp_rst_ff   <= reset_pll_enable_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_out_channel       = rsp_ch_ff;
   assign rsp_r_div_log2        = rsp_rexp_ff;
   assign rsp_ms_div            = rsp_div_ff;
   assign rsp_ms_p1             = rsp_ms_p1_ff;
   assign rsp_pll_mult_int      = rsp_a_ff;
   assign rsp_pll_frac_num      = rsp_b_ff;
   assign rsp_pll_p1            = rsp_p1_ff;
   assign rsp_pll_p2            = rsp_p2_ff;
   assign rsp_pll_reset_request = rsp_rst_ff;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// testbench for the clock synthesizer divider calculator: directed table and random requests
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
   import cdiv_pkg::*;

   localparam int NCH        = 3;
   localparam int LATENCY    = 78;
   localparam int CYCLE_MAX  = 1500000;
   localparam int NUM_RANDOM = 2000;

   typedef struct packed {
      logic [OUT_CH_W-1:0] out_channel;
      logic [REXP_W-1:0]   r_div_log2;
      logic [MSDIV_W-1:0]  ms_div;
      logic [P1_W-1:0]     ms_p1;
      logic [MULT_W-1:0]   pll_mult_int;
      logic [FRAC_W-1:0]   pll_frac_num;
      logic [P1_W-1:0]     pll_p1;
      logic [FRAC_W-1:0]   pll_p2;
      logic                pll_reset_request;
   } setting_type;

   // one directed row: request plus an optional typed expectation
   typedef struct {
      logic [IN_CH_W-1:0]   channel;
      logic [IN_FREQ_W-1:0] freq_hz;
      bit                   has_known;
      setting_type          known;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [IN_CH_W-1:0] req_channel = '0;
   logic [IN_FREQ_W-1:0] req_freq_hz = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [OUT_CH_W-1:0] rsp_out_channel;
   logic [REXP_W-1:0] rsp_r_div_log2;
   logic [MSDIV_W-1:0] rsp_ms_div;
   logic [P1_W-1:0] rsp_ms_p1;
   logic [MULT_W-1:0] rsp_pll_mult_int;
   logic [FRAC_W-1:0] rsp_pll_frac_num;
   logic [P1_W-1:0] rsp_pll_p1;
   logic [FRAC_W-1:0] rsp_pll_p2;
   logic rsp_pll_reset_request;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_write_data = '0;

   // predictor copy of the settings
   longint unsigned xtal_hz, out_min_hz, out_max_hz, ms_min, ms_max, mult_min, mult_max;
   bit pll_rst_en;

   setting_type expected_settings[$];
   int  fail_count = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;

   always #4 clock = ~clock;

   clock_synth_divider_calc_unit #(.NUM_CHANNELS(NCH)) u_top (.*);

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_MAX) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // predict the divider setting of one request
   function automatic setting_type predict_setting(logic [IN_CH_W-1:0] ch,
                                                   logic [IN_FREQ_W-1:0] freq);
      setting_type s;
      longint unsigned f, dv, vco, a, b, fq, p1, p2;
      int e;
      begin
         if (freq < 8000) e = 7;
         else if (freq < 16000) e = 6;
         else if (freq < 32000) e = 5;
         else if (freq < 64000) e = 4;
         else if (freq < 128000) e = 3;
         else if (freq < 256000) e = 2;
         else if (freq < 512000) e = 1;
         else e = 0;
         f = longint'(freq) << e;
         if (f < out_min_hz) f = out_min_hz;
         if (f > out_max_hz) f = out_max_hz;
         dv = (f == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd900000000 / f;
         if (dv > ms_max) dv = ms_max;
         if (dv < ms_min) dv = ms_min;
         dv = dv & ~64'd1;
         vco = dv * f;
         if (xtal_hz == 0) begin
            a = 64'hFFFF_FFFF_FFFF_FFFF;
            b = 0;
         end else begin
            a = vco / xtal_hz;
            b = ((vco % xtal_hz) * 64'd1048575) / xtal_hz;
         end
         if (a > mult_max) a = mult_max;
         if (a < mult_min) a = mult_min;
         fq = (128 * b) / 64'd1048575;
         p2 = 128 * b - 64'd1048575 * fq;
         p1 = 128 * a + fq - 512;
         s.out_channel       = (ch > NCH - 1) ? OUT_CH_W'(NCH - 1) : ch[OUT_CH_W-1:0];
         s.r_div_log2        = REXP_W'(e);
         s.ms_div            = dv[MSDIV_W-1:0];
         s.ms_p1             = P1_W'(128 * dv - 512);
         s.pll_mult_int      = a[MULT_W-1:0];
         s.pll_frac_num      = b[FRAC_W-1:0];
         s.pll_p1            = p1[P1_W-1:0];
         s.pll_p2            = p2[FRAC_W-1:0];
         s.pll_reset_request = pll_rst_en;
         return s;
      end
   endfunction

   // receiver stall and response check
   always @(posedge clock) begin
      setting_type w;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_settings.size() == 0) begin
               $error("unexpected response");
               fail_count++;
            end else begin
               w = expected_settings.pop_front();
               if (rsp_out_channel !== w.out_channel) begin
                  $error("out_channel exp %0d got %0d", w.out_channel, rsp_out_channel);
                  fail_count++;
               end
               if (rsp_r_div_log2 !== w.r_div_log2) begin
                  $error("r_div_log2 exp %0d got %0d", w.r_div_log2, rsp_r_div_log2);
                  fail_count++;
               end
               if (rsp_ms_div !== w.ms_div) begin
                  $error("ms_div exp %0d got %0d", w.ms_div, rsp_ms_div);
                  fail_count++;
               end
               if (rsp_ms_p1 !== w.ms_p1) begin
                  $error("ms_p1 exp %0d got %0d", w.ms_p1, rsp_ms_p1);
                  fail_count++;
               end
               if (rsp_pll_mult_int !== w.pll_mult_int) begin
                  $error("pll_mult_int exp %0d got %0d", w.pll_mult_int, rsp_pll_mult_int);
                  fail_count++;
               end
               if (rsp_pll_frac_num !== w.pll_frac_num) begin
                  $error("pll_frac_num exp %0d got %0d", w.pll_frac_num, rsp_pll_frac_num);
                  fail_count++;
               end
               if (rsp_pll_p1 !== w.pll_p1) begin
                  $error("pll_p1 exp %0d got %0d", w.pll_p1, rsp_pll_p1);
                  fail_count++;
               end
               if (rsp_pll_p2 !== w.pll_p2) begin
                  $error("pll_p2 exp %0d got %0d", w.pll_p2, rsp_pll_p2);
                  fail_count++;
               end
               if (rsp_pll_reset_request !== w.pll_reset_request) begin
                  $error("pll_reset_request exp %0d got %0d", w.pll_reset_request,
                         rsp_pll_reset_request);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // send one request, with random idle cycles before it
   task automatic send_request(logic [IN_CH_W-1:0] ch, logic [IN_FREQ_W-1:0] freq);
      begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid   <= 1'b1;
         req_channel <= ch;
         req_freq_hz <= freq;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         expected_settings.push_back(predict_setting(ch, freq));
      end
   endtask

   task automatic drain;
      begin
         req_valid <= 1'b0;
         while (expected_settings.size() != 0) @(posedge clock);
         repeat (LATENCY + 10) @(posedge clock);
      end
   endtask

   // write one register and mirror it into the predictor; write_all drops the enable
   task automatic write_reg(csr_idx_type idx, longint unsigned value);
      begin
         csr_write_enable <= 1'b1;
         csr_index        <= idx;
         csr_write_data   <= CSR_W'(value);
         @(posedge clock);
         case (idx)
            CSR_XTAL_HZ:      xtal_hz = value & 64'h3FFFFFF;
            CSR_OUT_MIN_HZ:   out_min_hz = value & 64'h1FFFFFFF;
            CSR_OUT_MAX_HZ:   out_max_hz = value & 64'h1FFFFFFF;
            CSR_MS_DIV_MIN:   ms_min = value & 64'hFFF;
            CSR_MS_DIV_MAX:   ms_max = value & 64'hFFF;
            CSR_PLL_MULT_MIN: mult_min = value & 64'hFF;
            CSR_PLL_MULT_MAX: mult_max = value & 64'hFF;
            CSR_RESET_PLL_EN: pll_rst_en = value[0];
            default: ;
         endcase
      end
   endtask

   task automatic write_all(longint unsigned x, longint unsigned lo, longint unsigned hi,
                            longint unsigned dmin, longint unsigned dmax,
                            longint unsigned mmin, longint unsigned mmax, bit rst_en);
      begin
         write_reg(CSR_XTAL_HZ, x);
         write_reg(CSR_OUT_MIN_HZ, lo);
         write_reg(CSR_OUT_MAX_HZ, hi);
         write_reg(CSR_MS_DIV_MIN, dmin);
         write_reg(CSR_MS_DIV_MAX, dmax);
         write_reg(CSR_PLL_MULT_MIN, mmin);
         write_reg(CSR_PLL_MULT_MAX, mmax);
         write_reg(CSR_RESET_PLL_EN, 64'(rst_en));
         csr_write_enable <= 1'b0;
      end
   endtask

   // random frequency, mostly below 600 kHz or in the useful range, some at band edges
   function automatic logic [IN_FREQ_W-1:0] random_freq();
      int k;
      begin
         k = $urandom_range(9);
         if (k < 3) return $urandom_range(600000);
         else if (k < 7) return $urandom_range(200000000, 500000);
         else if (k < 8) return (32'd8000 << $urandom_range(6)) - $urandom_range(1);
         else return $urandom;
      end
   endfunction

   task automatic random_phase(int count);
      begin
         for (int i = 0; i < count; i++) send_request(IN_CH_W'($urandom), random_freq());
         drain();
      end
   endtask

   row_type directed[$];

   initial begin
      row_type r;
      setting_type got;
      xtal_hz = 25000000; out_min_hz = 500000; out_max_hz = 200000000;
      ms_min = 4; ms_max = 900; mult_min = 15; mult_max = 90; pll_rst_en = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: band edges, channel clamp, field extremes
      r.has_known = 0; r.known = '0;
      r.channel = 0; r.freq_hz = 32'd0; directed.push_back(r);
      r.channel = 1; r.freq_hz = 32'd7999; directed.push_back(r);
      r.channel = 2; r.freq_hz = 32'd8000; directed.push_back(r);
      r.channel = 3; r.freq_hz = 32'd15999; directed.push_back(r);
      r.channel = 255; r.freq_hz = 32'd16000; directed.push_back(r);
      r.channel = 8'hAA; r.freq_hz = 32'd31999; directed.push_back(r);
      r.channel = 8'h55; r.freq_hz = 32'd32000; directed.push_back(r);
      r.channel = 0; r.freq_hz = 32'd63999; directed.push_back(r);
      r.channel = 1; r.freq_hz = 32'd64000; directed.push_back(r);
      r.channel = 2; r.freq_hz = 32'd127999; directed.push_back(r);
      r.channel = 0; r.freq_hz = 32'd128000; directed.push_back(r);
      r.channel = 0; r.freq_hz = 32'd255999; directed.push_back(r);
      r.channel = 0; r.freq_hz = 32'd256000; directed.push_back(r);
      r.channel = 0; r.freq_hz = 32'd511999; directed.push_back(r);
      r.channel = 0; r.freq_hz = 32'd512000; directed.push_back(r);
      r.channel = 0; r.freq_hz = 32'd100000000; directed.push_back(r);
      r.channel = 0; r.freq_hz = 32'hFFFFFFFF; directed.push_back(r);
      r.channel = 0; r.freq_hz = 32'h55555555; directed.push_back(r);
      // 200 MHz at reset settings: divider 4, vco 800 MHz, multiplier 32 exactly
      r.channel = 1; r.freq_hz = 32'd200000000; r.has_known = 1;
      r.known = '{out_channel: 2'd1, r_div_log2: 3'd0, ms_div: 12'd4, ms_p1: 18'd0,
                  pll_mult_int: 8'd32, pll_frac_num: 20'd0, pll_p1: 18'd3584,
                  pll_p2: 20'd0, pll_reset_request: 1'b0};
      directed.push_back(r);

      foreach (directed[i]) begin
         send_request(directed[i].channel, directed[i].freq_hz);
         if (directed[i].has_known) begin
            got = expected_settings[expected_settings.size() - 1];
            if (got !== directed[i].known) begin
               $error("directed row %0d: predictor exp %h got %h", i,
                      directed[i].known, got);
               fail_count++;
            end
            expected_settings[expected_settings.size() - 1] = directed[i].known;
         end
      end
      drain();

      // idling phases at reset settings
      send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(300);
      send_idle_pct = 75; recv_stall_pct = 0;  random_phase(200);
      send_idle_pct = 0;  recv_stall_pct = 75; random_phase(200);
      send_idle_pct = 15; recv_stall_pct = 15; random_phase(300);

      // extremes: crossed limits, zero crystal, zero window, reset request on
      write_all(0, 0, 0, 2048, 4, 255, 4, 1'b1);
      for (int i = 0; i < 20; i++) send_request(IN_CH_W'($urandom), random_freq());
      drain();
      write_all(50000000, 300000000, 1, 4, 2048, 4, 255, 1'b0);
      random_phase(150);
      write_all(8000000, 0, 300000000, 4, 2048, 4, 255, 1'b1);
      random_phase(250);
      write_all(26'h3FFFFFF, 12345, 29'h1FFFFFFF, 5, 7, 4, 4, 1'b0);
      random_phase(100);

      // random settings in range
      for (int p = 0; p < 5; p++) begin
         send_idle_pct = $urandom_range(1) * 30;
         recv_stall_pct = $urandom_range(1) * 30;
         write_all($urandom_range(50000000, 8000000), $urandom_range(2000000),
                   $urandom_range(300000000, 1000000), $urandom_range(20, 4),
                   $urandom_range(2048, 100), $urandom_range(20, 4),
                   $urandom_range(255, 60), 1'($urandom_range(1)));
         random_phase(100);
      end

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
